FILE: hdl/pcr_pkg.sv
package pcr_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 64;

    // Configuration register indexes.
    typedef enum logic [CfgIndexWidth-1:0] {
        REG_TARGET_LOW  = 3'd0,
        REG_TARGET_HIGH = 3'd1,
        REG_PERIOD_MIN  = 3'd2,
        REG_PERIOD_MAX  = 3'd3,
        REG_TEMP_OFFSET = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_ADJUST   = 2'd0,
        CMD_ARM_SKIP = 2'd1,
        CMD_STOP     = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    localparam logic [15:0] PeriodMinReset  = 16'd1142;
    localparam logic [15:0] PeriodMaxReset  = 16'd2399;
    localparam logic [15:0] TempOffsetReset = 16'd80;

    localparam logic [7:0]  LevelExempt     = 8'd9;
    localparam logic [16:0] NearMinMargin   = 17'd5;
    localparam logic [17:0] TargetBand      = 18'd2;

    typedef struct packed {
        logic [63:0]        target_low;
        logic [63:0]        target_high;
        logic [15:0]        period_min;
        logic [15:0]        period_max;
        logic signed [15:0] temp_offset;
    } pcr_cfg_t;

endpackage

FILE: hdl/pwm_current_regulator.sv
// Requests pass through the input register, then the result register; an output stall
// holds both. Throughput: one request per cycle when not stalled; the period register is
// read and rewritten in the same cycle, so back-to-back adjusts never wait on each other.
// Reset (rst_n, asynchronous, active low): period 1142, run and skip flags cleared,
// configuration registers to their defaults, both pipeline stages empty.
module pwm_current_regulator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           cmd,
    input  logic [7:0]                           level,
    input  logic [15:0]                          out_current,
    input  logic [15:0]                          in_current,
    input  logic signed [15:0]                   temp_first,
    input  logic signed [15:0]                   temp_second,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [15:0]                          period,
    output logic [14:0]                          duty_compare,
    output logic                                 running,
    output logic                                 near_min,
    output logic                                 reloaded,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pcr_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [pcr_pkg::CfgDataWidth-1:0]     cfg_data
);

    pcr_pkg::pcr_cfg_t cfg;

    pcr_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register.
    logic               in_valid_reg;
    logic [1:0]         cmd_reg;
    logic [7:0]         level_reg;
    logic [15:0]        out_current_reg;
    logic [15:0]        in_current_reg;
    logic signed [15:0] temp_first_reg;
    logic signed [15:0] temp_second_reg;

    // Regulator state.
    logic [15:0] period_reg, period_next;
    logic        run_reg, run_next;
    logic        skip_reg, skip_next;

    // Result register.
    logic        out_valid_reg;
    logic [15:0] period_out_reg;
    logic        near_min_reg, near_min_next;
    logic        reloaded_reg, reloaded_next;

    logic in_accept;
    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Derating and step decision.
    logic signed [15:0] hot;
    logic signed [17:0] excess;
    logic signed [17:0] level_wide;
    logic               derate;
    logic [7:0]         level_eff;
    logic               level_ok;
    logic [2:0]         slot;
    logic [15:0]        target;
    logic [19:0]        out_x4;
    logic [19:0]        in_x15;
    logic               ratio_high;
    logic               below_band;
    logic               above_band;
    logic               step;
    logic               step_down;
    logic [15:0]        stepped_period;
    logic [15:0]        clamped_period;

    always_comb
    begin
        hot        = (temp_first_reg >= temp_second_reg) ? temp_first_reg : temp_second_reg;
        excess     = $signed({{2{hot[15]}}, hot})
                   - $signed({{2{cfg.temp_offset[15]}}, cfg.temp_offset});
        level_wide = $signed({10'd0, level_reg});
        derate     = (excess > 18'sd0) && (level_reg != 8'd0)
                   && (level_reg != pcr_pkg::LevelExempt);
        if (!derate)
            level_eff = level_reg;
        else if (level_wide > excess)
            level_eff = level_reg - excess[7:0];
        else
            level_eff = 8'd1;
        level_ok = level_eff inside {[8'd1:8'd8]};

        slot   = level_eff[2:0] - 3'd1;
        target = slot[2] ? cfg.target_high[{slot[1:0], 4'd0} +: 16]
                         : cfg.target_low[{slot[1:0], 4'd0} +: 16];

        // 4*out >= 15*in, with 15*in formed as 16*in - in.
        out_x4     = {2'd0, out_current_reg, 2'd0};
        in_x15     = {in_current_reg, 4'd0} - {4'd0, in_current_reg};
        ratio_high = (in_current_reg != 16'd0) && (out_x4 >= in_x15);
        below_band = ({2'd0, out_current_reg} + pcr_pkg::TargetBand) < {2'd0, target};
        above_band = {2'd0, out_current_reg} > ({2'd0, target} + pcr_pkg::TargetBand);

        step      = skip_reg || ratio_high || below_band || above_band;
        step_down = skip_reg || ratio_high || !below_band;

        stepped_period = step_down ? period_reg - 16'd1 : period_reg + 16'd1;
        if (stepped_period < cfg.period_min)
            clamped_period = cfg.period_min;
        else if (stepped_period > cfg.period_max)
            clamped_period = cfg.period_max;
        else
            clamped_period = stepped_period;

        period_next   = period_reg;
        run_next      = run_reg;
        skip_next     = skip_reg;
        reloaded_next = 1'b0;
        case (cmd_reg)
            pcr_pkg::CMD_ADJUST:
            begin
                if (!level_ok)
                begin
                    period_next = cfg.period_min;
                    run_next    = 1'b0;
                end
                else
                begin
                    run_next = 1'b1;
                    if (step)
                    begin
                        period_next   = clamped_period;
                        skip_next     = 1'b0;
                        reloaded_next = 1'b1;
                    end
                end
            end
            pcr_pkg::CMD_ARM_SKIP:
                skip_next = 1'b1;
            pcr_pkg::CMD_STOP:
            begin
                period_next = cfg.period_min;
                run_next    = 1'b0;
            end
            default: ;
        endcase

        near_min_next = {1'b0, period_next} <= ({1'b0, cfg.period_min} + pcr_pkg::NearMinMargin);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            period_reg    <= pcr_pkg::PeriodMinReset;
            run_reg       <= 1'b0;
            skip_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                period_reg    <= period_next;
                run_reg       <= run_next;
                skip_reg      <= skip_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg         <= cmd;
            level_reg       <= level;
            out_current_reg <= out_current;
            in_current_reg  <= in_current;
            temp_first_reg  <= temp_first;
            temp_second_reg <= temp_second;
        end
        if (advance)
        begin
            period_out_reg <= period_next;
            near_min_reg   <= near_min_next;
            reloaded_reg   <= reloaded_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign period       = period_out_reg;
    assign duty_compare = period_out_reg[15:1];
    assign running      = run_reg;
    assign near_min     = near_min_reg;
    assign reloaded     = reloaded_reg;

    // A stepped period only comes from an adjust request, which also enables the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reloaded |-> running)
        else $error("stepped period reported with PWM stopped");

    // The input side only stalls while a result is held up at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back pressure");

    // A new result is always drawn from a request held in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid_reg))
        else $error("result produced without a pending request");

endmodule

FILE: hdl/pcr_regs.sv
module pcr_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pcr_pkg::CfgIndexWidth-1:0]    cfg_index,
    input  logic [pcr_pkg::CfgDataWidth-1:0]     cfg_data,
    output pcr_pkg::pcr_cfg_t                    cfg
);

    pcr_pkg::pcr_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_low  <= '0;
            cfg_reg.target_high <= '0;
            cfg_reg.period_min  <= pcr_pkg::PeriodMinReset;
            cfg_reg.period_max  <= pcr_pkg::PeriodMaxReset;
            cfg_reg.temp_offset <= pcr_pkg::TempOffsetReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pcr_pkg::REG_TARGET_LOW:  cfg_reg.target_low  <= cfg_data;
                pcr_pkg::REG_TARGET_HIGH: cfg_reg.target_high <= cfg_data;
                pcr_pkg::REG_PERIOD_MIN:  cfg_reg.period_min  <= cfg_data[15:0];
                pcr_pkg::REG_PERIOD_MAX:  cfg_reg.period_max  <= cfg_data[15:0];
                pcr_pkg::REG_TEMP_OFFSET: cfg_reg.temp_offset <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WatchdogLimit = 3000;
    localparam int unsigned HoldOffCycles = 80;
    localparam int unsigned ItemsPerSetting = 220;

    typedef struct {
        logic [15:0] period;
        logic [14:0] duty_compare;
        logic        running;
        logic        near_min;
        logic        reloaded;
    } regulator_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = pcr_pkg::CMD_NOP;
    logic [7:0]         level = '0;
    logic [15:0]        out_current = '0;
    logic [15:0]        in_current = '0;
    logic signed [15:0] temp_first = '0;
    logic signed [15:0] temp_second = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [15:0]        period;
    logic [14:0]        duty_compare;
    logic               running;
    logic               near_min;
    logic               reloaded;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [pcr_pkg::CfgIndexWidth-1:0] cfg_index = '0;
    logic [pcr_pkg::CfgDataWidth-1:0]  cfg_data = '0;

    // Shadow copy of the configuration and of the regulator state.
    logic [63:0]        target_low_cfg = '0;
    logic [63:0]        target_high_cfg = '0;
    logic [15:0]        period_min_cfg = pcr_pkg::PeriodMinReset;
    logic [15:0]        period_max_cfg = pcr_pkg::PeriodMaxReset;
    logic signed [15:0] temp_offset_cfg = pcr_pkg::TempOffsetReset;
    logic [15:0]        period_now = pcr_pkg::PeriodMinReset;
    logic               run_flag = 1'b0;
    logic               skip_flag = 1'b0;

    regulator_result_t expected_results[$];
    int unsigned error_count = 0;

    int unsigned sender_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_seq = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    pwm_current_regulator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .level        (level),
        .out_current  (out_current),
        .in_current   (in_current),
        .temp_first   (temp_first),
        .temp_second  (temp_second),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .period       (period),
        .duty_compare (duty_compare),
        .running      (running),
        .near_min     (near_min),
        .reloaded     (reloaded),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] target_of(int lvl);
        logic [63:0] bank;
        int          slot;
        bank = (lvl <= 4) ? target_low_cfg : target_high_cfg;
        slot = (lvl - 1) & 3;
        return bank[slot*16 +: 16];
    endfunction

    task automatic step_period(input logic up);
        logic [15:0] p;
        p = up ? period_now + 16'd1 : period_now - 16'd1;
        if (p < period_min_cfg)
            p = period_min_cfg;
        else if (p > period_max_cfg)
            p = period_max_cfg;
        period_now = p;
    endtask

    task automatic advance_regulator(
        input  pcr_pkg::cmd_t      op,
        input  logic [7:0]         lvl_in,
        input  logic [15:0]        oc,
        input  logic [15:0]        ic,
        input  logic signed [15:0] t1,
        input  logic signed [15:0] t2,
        output regulator_result_t  res
    );
        int   hot;
        int   excess;
        int   lvl;
        int   tgt;
        logic stepped;
        stepped = 1'b0;
        case (op)
            pcr_pkg::CMD_ADJUST:
            begin
                hot = (t1 >= t2) ? int'(t1) : int'(t2);
                excess = hot - int'(temp_offset_cfg);
                lvl = int'(lvl_in);
                if (excess > 0 && lvl != 0 && lvl != int'(pcr_pkg::LevelExempt))
                    lvl = (lvl > excess) ? lvl - excess : 1;
                if (lvl < 1 || lvl > 8)
                begin
                    period_now = period_min_cfg;
                    run_flag = 1'b0;
                end
                else
                begin
                    tgt = int'(target_of(lvl));
                    stepped = 1'b1;
                    if (skip_flag)
                    begin
                        step_period(1'b0);
                        skip_flag = 1'b0;
                    end
                    else if (ic != 0 && 4 * int'(oc) >= 15 * int'(ic))
                        step_period(1'b0);
                    else if (int'(oc) < tgt - 2)
                        step_period(1'b1);
                    else if (int'(oc) > tgt + 2)
                        step_period(1'b0);
                    else
                        stepped = 1'b0;
                    run_flag = 1'b1;
                end
            end
            pcr_pkg::CMD_ARM_SKIP: skip_flag = 1'b1;
            pcr_pkg::CMD_STOP:
            begin
                period_now = period_min_cfg;
                run_flag = 1'b0;
            end
            default: ;
        endcase
        res.period = period_now;
        res.duty_compare = period_now[15:1];
        res.running = run_flag;
        res.near_min = int'(period_now) <= int'(period_min_cfg) + 5;
        res.reloaded = stepped;
    endtask

    // Offers one request, waits until it is taken and records what it must produce.
    task automatic send_request(
        input pcr_pkg::cmd_t      op,
        input logic [7:0]         lvl,
        input logic [15:0]        oc,
        input logic [15:0]        ic,
        input logic signed [15:0] t1,
        input logic signed [15:0] t2
    );
        regulator_result_t res;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        level <= lvl;
        out_current <= oc;
        in_current <= ic;
        temp_first <= t1;
        temp_second <= t2;
        do
            @(posedge clk);
        while (in_stall);
        advance_regulator(op, lvl, oc, ic, t1, t2, res);
        expected_results.push_back(res);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input pcr_pkg::reg_index_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            pcr_pkg::REG_TARGET_LOW:  target_low_cfg = value;
            pcr_pkg::REG_TARGET_HIGH: target_high_cfg = value;
            pcr_pkg::REG_PERIOD_MIN:  period_min_cfg = value[15:0];
            pcr_pkg::REG_PERIOD_MAX:  period_max_cfg = value[15:0];
            pcr_pkg::REG_TEMP_OFFSET: temp_offset_cfg = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_settings(
        input logic [63:0] tgt_low,
        input logic [63:0] tgt_high,
        input logic [15:0] pmin,
        input logic [15:0] pmax,
        input logic [15:0] offset
    );
        wait_idle();
        write_register(pcr_pkg::REG_TARGET_LOW, tgt_low);
        write_register(pcr_pkg::REG_TARGET_HIGH, tgt_high);
        write_register(pcr_pkg::REG_PERIOD_MIN, {48'd0, pmin});
        write_register(pcr_pkg::REG_PERIOD_MAX, {48'd0, pmax});
        write_register(pcr_pkg::REG_TEMP_OFFSET, {48'd0, offset});
    endtask

    task automatic randomize_settings();
        logic [15:0] pmin;
        logic [15:0] pmax;
        logic [15:0] offset;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            pmin = 16'($urandom_range(3000, 100));
            pmax = pmin + 16'($urandom_range(60));
        end
        else if (pick < 85)
        begin
            pmin = 16'($urandom);
            pmax = 16'($urandom);
        end
        else
        begin
            // Minimum above maximum: every clamped step lands on the minimum or the maximum.
            pmax = 16'($urandom_range(2000, 100));
            pmin = pmax + 16'($urandom_range(40, 1));
        end
        offset = ($urandom_range(99) < 80) ? 16'($urandom_range(120, 40)) : 16'($urandom);
        write_settings({$urandom, $urandom}, {$urandom, $urandom}, pmin, pmax, offset);
    endtask

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    // Mostly valid adjust requests with currents close to the level's target, so the
    // period walks between its limits; the rest is arbitrary.
    task automatic random_request();
        pcr_pkg::cmd_t      op;
        logic [7:0]         lvl;
        logic [15:0]        oc;
        logic [15:0]        ic;
        logic signed [15:0] t1;
        logic signed [15:0] t2;
        int unsigned        pick;
        int                 v;
        pick = $urandom_range(99);
        op = (pick < 80) ? pcr_pkg::CMD_ADJUST : (pick < 88) ? pcr_pkg::CMD_ARM_SKIP :
             (pick < 94) ? pcr_pkg::CMD_STOP : pcr_pkg::CMD_NOP;
        lvl = ($urandom_range(99) < 85) ? 8'($urandom_range(8, 1)) : 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            t1 = clip16(temp_offset_cfg - int'($urandom_range(60)));
            t2 = clip16(temp_offset_cfg - int'($urandom_range(60)));
        end
        else if (pick < 85)
        begin
            t1 = clip16(temp_offset_cfg + int'($urandom_range(8, 1)));
            t2 = clip16(temp_offset_cfg - int'($urandom_range(60)));
        end
        else
        begin
            t1 = 16'($urandom);
            t2 = 16'($urandom);
        end
        if ($urandom_range(99) < 60 && lvl >= 1 && lvl <= 8)
        begin
            v = int'(target_of(lvl)) + int'($urandom_range(10)) - 5;
            oc = (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
        end
        else
            oc = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 50)
            ic = '0;
        else if (pick < 80)
            ic = 16'($urandom);
        else
            ic = 16'((int'(oc) * 4) / 15 + int'($urandom_range(2)));
        send_request(op, lvl, oc, ic, t1, t2);
    endtask

    task automatic test_directed_cases();
        write_settings({16'd4000, 16'd3000, 16'd2000, 16'd1000},
                       {16'hFFFF, 16'd7000, 16'd6000, 16'd5000},
                       pcr_pkg::PeriodMinReset, pcr_pkg::PeriodMaxReset,
                       pcr_pkg::TempOffsetReset);
        send_request(pcr_pkg::CMD_NOP, 8'd1, 16'd0, 16'd0, 16'sd20, 16'sd20);
        send_request(pcr_pkg::CMD_ADJUST, 8'd1, 16'd500, 16'd0, 16'sd20, 16'sd25);
        send_request(pcr_pkg::CMD_ADJUST, 8'd1, 16'd1002, 16'd0, 16'sd20, 16'sd25);
        send_request(pcr_pkg::CMD_ADJUST, 8'd1, 16'd1003, 16'd0, 16'sd20, 16'sd25);
        send_request(pcr_pkg::CMD_ADJUST, 8'd1, 16'd997, 16'd0, 16'sd20, 16'sd25);
        send_request(pcr_pkg::CMD_ADJUST, 8'd1, 16'd998, 16'd0, 16'sd20, 16'sd25);
        // Current ratio exactly at the limit steps down; just below it does not.
        send_request(pcr_pkg::CMD_ADJUST, 8'd1, 16'd15, 16'd4, 16'sd20, 16'sd25);
        send_request(pcr_pkg::CMD_ADJUST, 8'd1, 16'd14, 16'd4, 16'sd20, 16'sd25);
        send_request(pcr_pkg::CMD_ARM_SKIP, 8'd0, 16'd0, 16'd0, 16'sd0, 16'sd0);
        send_request(pcr_pkg::CMD_ADJUST, 8'd8, 16'd0, 16'd0, 16'sd0, 16'sd0);
        send_request(pcr_pkg::CMD_ADJUST, 8'd8, 16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0);
        send_request(pcr_pkg::CMD_ADJUST, 8'd0, 16'd1000, 16'd0, 16'sd0, 16'sd0);
        send_request(pcr_pkg::CMD_ADJUST, 8'd9, 16'd1000, 16'd0, 16'sd32767, 16'sd32767);
        send_request(pcr_pkg::CMD_ADJUST, 8'd255, 16'd1000, 16'd0, 16'sd0, 16'sd0);
        // Derating: excess below and equal to the level.
        send_request(pcr_pkg::CMD_ADJUST, 8'd4, 16'd0, 16'd0, 16'sd83, -16'sd32768);
        send_request(pcr_pkg::CMD_ADJUST, 8'd3, 16'd0, 16'd0, 16'sd0, 16'sd83);
        send_request(pcr_pkg::CMD_ADJUST, 8'd5, 16'd0, 16'd0, 16'sd60, 16'sd83);
        send_request(pcr_pkg::CMD_ADJUST, 8'd7, 16'hFFFF, 16'd0, -16'sd32768, -16'sd32768);
        send_request(pcr_pkg::CMD_ARM_SKIP, 8'hFF, 16'hFFFF, 16'hFFFF, -16'sd1, -16'sd1);
        send_request(pcr_pkg::CMD_STOP, 8'd4, 16'd0, 16'd0, 16'sd0, 16'sd0);
        send_request(pcr_pkg::CMD_ADJUST, 8'd2, 16'd0, 16'hFFFF, 16'sd0, 16'sd0);
        send_request(pcr_pkg::CMD_NOP, 8'd0, 16'd0, 16'd0, 16'sd0, 16'sd0);
    endtask

    task automatic test_config_extremes();
        // Period range from 0 to 65534, close to both ends of the 16-bit range.
        write_settings('1, '0, 16'd0, 16'd65534, 16'h8000);
        send_request(pcr_pkg::CMD_STOP, 8'd1, 16'd0, 16'd0, 16'sd0, 16'sd0);
        send_request(pcr_pkg::CMD_ADJUST, 8'd1, 16'd100, 16'd0, -16'sd32768, -16'sd32768);
        send_request(pcr_pkg::CMD_ADJUST, 8'd6, 16'd100, 16'd0, 16'sd10, -16'sd32768);
        send_request(pcr_pkg::CMD_ADJUST, 8'd8, 16'd0, 16'd0, -16'sd32768, -16'sd32768);
        // Minimum above maximum, top offset so nothing derates.
        write_settings({4{16'd500}}, '1, 16'd65535, 16'd0, 16'h7FFF);
        send_request(pcr_pkg::CMD_ADJUST, 8'd2, 16'd0, 16'd0, 16'sd32767, 16'sd32767);
        send_request(pcr_pkg::CMD_ADJUST, 8'd8, 16'd65535, 16'd1, 16'sd0, 16'sd0);
        send_request(pcr_pkg::CMD_STOP, 8'd0, 16'd0, 16'd0, 16'sd0, 16'sd0);
        send_request(pcr_pkg::CMD_ADJUST, 8'd3, 16'd400, 16'd0, 16'sd0, 16'sd0);
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct);
        sender_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (3)
        begin
            randomize_settings();
            repeat (ItemsPerSetting) random_request();
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_back_pressure();
        wait_idle();
        sender_idle_pct = 0;
        recv_idle_pct = 0;
        hold_seq++;
        repeat (60) random_request();
    endtask

    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HoldOffCycles;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        regulator_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending: period %0d", period);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (period !== want.period)
                begin
                    $error("period: expected %0d, got %0d", want.period, period);
                    error_count++;
                end
                if (duty_compare !== want.duty_compare)
                begin
                    $error("duty_compare: expected %0d, got %0d",
                           want.duty_compare, duty_compare);
                    error_count++;
                end
                if (running !== want.running)
                begin
                    $error("running: expected %0b, got %0b", want.running, running);
                    error_count++;
                end
                if (near_min !== want.near_min)
                begin
                    $error("near_min: expected %0b, got %0b", want.near_min, near_min);
                    error_count++;
                end
                if (reloaded !== want.reloaded)
                begin
                    $error("reloaded: expected %0b, got %0b", want.reloaded, reloaded);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("FAIL pwm_current_regulator");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_config_extremes();
        test_random_traffic(30, 77);
        test_back_pressure();
        test_random_traffic(77, 30);
        test_random_traffic(0, 0);
        wait_idle();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASS pwm_current_regulator");
        else
            $display("FAIL pwm_current_regulator");
        $finish;
    end

endmodule
